### hdl/assert_macros.svh
// assertion macros shared by the camera view transform modules
// each module that checks itself includes this file and has clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its trigger
`define ASSERT_SAME(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error(msg);

// property holds in the cycle after its trigger
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

### hdl/cvt_pkg.sv
// shared constants for the camera view transform
// no dependencies
package cvt_pkg;

  // integer bits of a trig value, the rest of the word is fraction
  localparam int TRIG_INT_BITS = 2;

  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CAM_X     = 3'd0,
    REG_CAM_Y     = 3'd1,
    REG_CAM_Z     = 3'd2,
    REG_COS_PITCH = 3'd3,
    REG_SIN_PITCH = 3'd4,
    REG_COS_YAW   = 3'd5,
    REG_SIN_YAW   = 3'd6
  } cfg_index_t;

endpackage

### hdl/cvt_rot.sv
// two-stage plane rotation: products, then sum, round and saturate
// depends on cvt_pkg and assert_macros.svh
`include "assert_macros.svh"

module cvt_rot #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] a1,
  input  logic signed [COORD_WIDTH-1:0] a2,
  input  logic signed [COORD_WIDTH-1:0] carry_in,
  input  logic signed [TRIG_WIDTH-1:0]  cos_val,
  input  logic signed [TRIG_WIDTH-1:0]  sin_val,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] r1,
  output logic signed [COORD_WIDTH-1:0] r2,
  output logic signed [COORD_WIDTH-1:0] carry_out
);

  localparam int FRAC = TRIG_WIDTH - cvt_pkg::TRIG_INT_BITS;
  localparam int PW   = COORD_WIDTH + TRIG_WIDTH;
  localparam int SW   = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC - 1);

  // r1 = a1*cos - a2*sin, r2 = a1*sin + a2*cos
  function automatic logic signed [COORD_WIDTH-1:0] round_sat(
    input logic signed [PW-1:0] x,
    input logic signed [PW-1:0] y,
    input logic                 sub
  );
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] q;
    logic                 ovf;
    begin
      s   = sub ? (SW'(x) - SW'(y) + HALF) : (SW'(x) + SW'(y) + HALF);
      q   = s >>> FRAC;
      ovf = (q[SW-1:COORD_WIDTH-1] != {(SW-COORD_WIDTH+1){q[SW-1]}});
      if (ovf) begin
        round_sat = {q[SW-1], {(COORD_WIDTH-1){~q[SW-1]}}};
      end else begin
        round_sat = q[COORD_WIDTH-1:0];
      end
    end
  endfunction

  logic                          va;
  logic signed [PW-1:0]          p1c;
  logic signed [PW-1:0]          p2s;
  logic signed [PW-1:0]          p1s;
  logic signed [PW-1:0]          p2c;
  logic signed [COORD_WIDTH-1:0] carry_a;
  logic                          vb;
  logic                          en_a;
  logic                          en_b;
  logic signed [PW-1:0]          m1c;
  logic signed [PW-1:0]          m2s;
  logic signed [PW-1:0]          m1s;
  logic signed [PW-1:0]          m2c;

  assign en_b     = !vb || out_ready;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;
  assign out_valid = vb;

  assign m1c = PW'(a1) * PW'(cos_val);
  assign m2s = PW'(a2) * PW'(sin_val);
  assign m1s = PW'(a1) * PW'(sin_val);
  assign m2c = PW'(a2) * PW'(cos_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      p1c     <= m1c;
      p2s     <= m2s;
      p1s     <= m1s;
      p2c     <= m2c;
      carry_a <= carry_in;
    end
    if (en_b && va) begin
      r1        <= round_sat(p1c, p2s, 1'b1);
      r2        <= round_sat(p1s, p2c, 1'b0);
      carry_out <= carry_a;
    end
  end

  `ASSERT_NEXT(a_rot_fill, in_valid && in_ready, va, "accepted item did not reach product stage")
  `ASSERT_NEXT(a_rot_move, va && !vb, vb, "product stage item did not advance into empty slot")
  `ASSERT_NEXT(a_rot_hold, vb && !out_ready, vb && $stable(r1) && $stable(r2),
               "stalled result lost or changed")

endmodule

### hdl/camera_view_transform.sv
// camera view transform top level: subtract camera position, pitch then yaw
// depends on cvt_pkg, cvt_rot and assert_macros.svh
//
//   channel   signals                               direction
//   in        in_valid/in_ready, point_x/y/z        into block
//   out       out_valid/out_ready, view_x/y/z       out of block
//   cfg       cfg_we, cfg_index, cfg_data           into block, write only
//
// five register stages: subtract, pitch products, pitch sums, yaw products,
// yaw sums; one item is accepted every cycle while the output is not stalled.
// each stage holds its own valid bit and moves when the next one is free,
// so a stall at the output backs up stage by stage and bubbles are filled.
// rst clears the valid bits and loads identity rotation with camera at origin.
`include "assert_macros.svh"

module camera_view_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_WIDTH-1:0]          point_x,
  input  logic signed [COORD_WIDTH-1:0]          point_y,
  input  logic signed [COORD_WIDTH-1:0]          point_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [COORD_WIDTH-1:0]          view_x,
  output logic signed [COORD_WIDTH-1:0]          view_y,
  output logic signed [COORD_WIDTH-1:0]          view_z,
  input  logic                                   cfg_we,
  input  logic [cvt_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [((COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH)-1:0] cfg_data
);

  localparam int FRAC = TRIG_WIDTH - cvt_pkg::TRIG_INT_BITS;
  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(1) <<< FRAC;

  function automatic logic signed [COORD_WIDTH-1:0] sub_sat(
    input logic signed [COORD_WIDTH-1:0] p,
    input logic signed [COORD_WIDTH-1:0] c
  );
    logic signed [COORD_WIDTH:0] d;
    begin
      d = {p[COORD_WIDTH-1], p} - {c[COORD_WIDTH-1], c};
      if (d[COORD_WIDTH] != d[COORD_WIDTH-1]) begin
        sub_sat = {d[COORD_WIDTH], {(COORD_WIDTH-1){~d[COORD_WIDTH]}}};
      end else begin
        sub_sat = d[COORD_WIDTH-1:0];
      end
    end
  endfunction

  logic signed [COORD_WIDTH-1:0] cam_x;
  logic signed [COORD_WIDTH-1:0] cam_y;
  logic signed [COORD_WIDTH-1:0] cam_z;
  logic signed [TRIG_WIDTH-1:0]  pitch_cos;
  logic signed [TRIG_WIDTH-1:0]  pitch_sin;
  logic signed [TRIG_WIDTH-1:0]  yaw_cos;
  logic signed [TRIG_WIDTH-1:0]  yaw_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x     <= '0;
      cam_y     <= '0;
      cam_z     <= '0;
      pitch_cos <= TRIG_ONE;
      pitch_sin <= '0;
      yaw_cos   <= TRIG_ONE;
      yaw_sin   <= '0;
    end else if (cfg_we) begin
      unique case (cvt_pkg::cfg_index_t'(cfg_index))
        cvt_pkg::REG_CAM_X:     cam_x     <= cfg_data[COORD_WIDTH-1:0];
        cvt_pkg::REG_CAM_Y:     cam_y     <= cfg_data[COORD_WIDTH-1:0];
        cvt_pkg::REG_CAM_Z:     cam_z     <= cfg_data[COORD_WIDTH-1:0];
        cvt_pkg::REG_COS_PITCH: pitch_cos <= cfg_data[TRIG_WIDTH-1:0];
        cvt_pkg::REG_SIN_PITCH: pitch_sin <= cfg_data[TRIG_WIDTH-1:0];
        cvt_pkg::REG_COS_YAW:   yaw_cos   <= cfg_data[TRIG_WIDTH-1:0];
        cvt_pkg::REG_SIN_YAW:   yaw_sin   <= cfg_data[TRIG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: point minus camera
  logic                          v1;
  logic                          en1;
  logic signed [COORD_WIDTH-1:0] rx;
  logic signed [COORD_WIDTH-1:0] ry;
  logic signed [COORD_WIDTH-1:0] rz;
  logic                          pitch_ready;

  assign en1      = !v1 || pitch_ready;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      rx <= sub_sat(point_x, cam_x);
      ry <= sub_sat(point_y, cam_y);
      rz <= sub_sat(point_z, cam_z);
    end
  end

  // pitch: yp = ry*cos - rz*sin, zp = ry*sin + rz*cos, rx rides along
  logic                          pv;
  logic                          yaw_ready;
  logic signed [COORD_WIDTH-1:0] yp;
  logic signed [COORD_WIDTH-1:0] zp;
  logic signed [COORD_WIDTH-1:0] rx_p;

  cvt_rot #(
    .COORD_WIDTH(COORD_WIDTH),
    .TRIG_WIDTH (TRIG_WIDTH)
  ) u_pitch (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .in_ready (pitch_ready),
    .a1       (ry),
    .a2       (rz),
    .carry_in (rx),
    .cos_val  (pitch_cos),
    .sin_val  (pitch_sin),
    .out_valid(pv),
    .out_ready(yaw_ready),
    .r1       (yp),
    .r2       (zp),
    .carry_out(rx_p)
  );

  // yaw: z = zp*cos - rx*sin, x = zp*sin + rx*cos, yp rides along
  cvt_rot #(
    .COORD_WIDTH(COORD_WIDTH),
    .TRIG_WIDTH (TRIG_WIDTH)
  ) u_yaw (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pv),
    .in_ready (yaw_ready),
    .a1       (zp),
    .a2       (rx_p),
    .carry_in (yp),
    .cos_val  (yaw_cos),
    .sin_val  (yaw_sin),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .r1       (view_z),
    .r2       (view_x),
    .carry_out(view_y)
  );

  `ASSERT_SAME(a_top_flow, out_ready, in_ready, "input blocked while output drains")
  `ASSERT_NEXT(a_top_entry, in_valid && in_ready, v1, "accepted item missing from first stage")
  `ASSERT_NEXT(a_top_hold, v1 && !pitch_ready, v1 && $stable(rx) && $stable(ry) && $stable(rz),
               "stalled first stage item lost or changed")

endmodule

### tb/tb_camera_view_transform.sv
`timescale 1ns / 100ps
// testbench for camera_view_transform: directed table, then random register phases and points
// depends on cvt_pkg and the camera_view_transform rtl; results checked against a local predictor

module tb_camera_view_transform;

  localparam int CW   = 32;
  localparam int TW   = 16;
  localparam int IW   = cvt_pkg::CFG_INDEX_WIDTH;
  localparam int FRAC = TW - cvt_pkg::TRIG_INT_BITS;
  localparam logic [IW-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [CW-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
  localparam int PLAN_LEN = 35;
  localparam int PHASES = 29;
  localparam int PHASE_ITEMS = 50;

  typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [IW-1:0] idx;
    logic [CW-1:0] data;
    vec_t          pt;
    logic          known;
    vec_t          res;
  } step_t;

  // known results are given in the table; the first ones are plain copies of the point under identity rotation
  localparam step_t PLAN [PLAN_LEN] = '{
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 32'h0}},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0,
      '{32'h0001_0000, 32'hffff_0000, 32'h0002_0000}, 1'b1,
      '{32'h0001_0000, 32'hffff_0000, 32'h0002_0000}},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{C_MAX, C_MIN, C_MAX}, 1'b1, '{C_MAX, C_MIN, C_MAX}},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{C_MIN, C_MAX, C_MIN}, 1'b1, '{C_MIN, C_MAX, C_MIN}},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0,
      '{32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f}, 1'b1,
      '{32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f}},
    // camera at extremes, differences saturate
    '{ROW_CFG, cvt_pkg::REG_CAM_X, C_MIN, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_CAM_Y, C_MAX, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_CAM_Z, 32'h0001_0000, '0, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{C_MAX, C_MIN, 32'h0}, 1'b1,
      '{C_MAX, C_MIN, 32'hffff_0000}},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{32'h0, 32'h0, C_MIN}, 1'b1,
      '{C_MAX, 32'h8000_0001, C_MIN}},
    // quarter turns; upper data bits of a trig write are dropped
    '{ROW_CFG, cvt_pkg::REG_CAM_X, 32'h0, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_CAM_Y, 32'h0, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_CAM_Z, 32'h0, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_COS_PITCH, 32'h0, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_SIN_PITCH, 32'hffff_4000, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_COS_YAW, 32'h0, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_SIN_YAW, 32'h0000_4000, '0, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0,
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{C_MAX, C_MAX, C_MIN}, 1'b0, '0},
    // trig codes beyond one, most negative code used unclamped
    '{ROW_CFG, cvt_pkg::REG_COS_PITCH, 32'h0000_8000, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_SIN_PITCH, 32'h0000_8000, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_COS_YAW, 32'h0000_7fff, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_SIN_YAW, 32'h0000_8000, '0, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{C_MAX, C_MIN, C_MAX}, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{32'h1, 32'hffff_ffff, 32'h1}, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{32'hffff_ffff, 32'h0, C_MIN}, 1'b0, '0},
    // write to an unused index must change nothing
    '{ROW_CFG, REG_UNUSED, 32'hffff_ffff, '0, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0,
      '{32'h0000_8000, 32'h7fff_0000, 32'h8001_0000}, 1'b0, '0},
    // half scale: ties round toward plus infinity
    '{ROW_CFG, cvt_pkg::REG_COS_PITCH, 32'h0000_2000, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_SIN_PITCH, 32'h0, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_COS_YAW, 32'h0000_2000, '0, 1'b0, '0},
    '{ROW_CFG, cvt_pkg::REG_SIN_YAW, 32'h0, '0, 1'b0, '0},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{32'h1, 32'h1, 32'h1}, 1'b1, '{32'h1, 32'h1, 32'h1}},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0,
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b1,
      '{32'h0, 32'h0, 32'h0}},
    '{ROW_POINT, cvt_pkg::REG_CAM_X, '0, '{32'h3, 32'hffff_fffd, 32'h5}, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic signed [CW-1:0] point_z = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CW-1:0] view_x;
  logic signed [CW-1:0] view_y;
  logic signed [CW-1:0] view_z;
  logic                 cfg_we = 1'b0;
  logic [IW-1:0]        cfg_index = '0;
  logic [CW-1:0]        cfg_data = '0;

  // register copies as the block should hold them
  longint eye_x = 0, eye_y = 0, eye_z = 0;
  longint cos_p = longint'(1) <<< FRAC, sin_p = 0;
  longint cos_y = longint'(1) <<< FRAC, sin_y = 0;

  vec_t views_due[$];
  int   mismatches = 0;
  bit   steady = 1'b0;

  camera_view_transform #(.COORD_WIDTH(CW), .TRIG_WIDTH(TW)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .view_x(view_x), .view_y(view_y), .view_z(view_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_camera_view_transform NOT OK");
    $finish;
  end

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return v[CW-1:0];
  endfunction

  // exact two-term dot product, round half up, saturate
  function automatic logic signed [CW-1:0] rot_pair(longint a1, longint b1, longint a2, longint b2);
    longint acc;
    acc = a1 * b1 + a2 * b2 + (longint'(1) <<< (FRAC - 1));
    return clamp_coord(acc >>> FRAC);
  endfunction

  function automatic vec_t camera_view(vec_t p);
    longint rx, ry, rz, zp;
    vec_t v;
    rx = longint'(clamp_coord(longint'($signed(p.x)) - eye_x));
    ry = longint'(clamp_coord(longint'($signed(p.y)) - eye_y));
    rz = longint'(clamp_coord(longint'($signed(p.z)) - eye_z));
    zp = longint'(rot_pair(ry, sin_p, rz, cos_p));
    v.y = rot_pair(ry, cos_p, rz, -sin_p);
    v.x = rot_pair(rx, cos_y, zp, sin_y);
    v.z = rot_pair(rx, -sin_y, zp, cos_y);
    return v;
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(7))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3, 4: return CW'(int'($urandom_range(1 << 19)) - (1 << 18));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_trig();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return '0;
      5: return TW'($urandom());
      default: return TW'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic vec_t pick_point();
    vec_t p;
    if ($urandom_range(3) == 0) begin
      p = '{pick_coord(), pick_coord(), pick_coord()};
    end else begin
      // near the camera, so results stay mostly unsaturated
      p.x = CW'(eye_x + longint'(int'($urandom_range(1 << 21)) - (1 << 20)));
      p.y = CW'(eye_y + longint'(int'($urandom_range(1 << 21)) - (1 << 20)));
      p.z = CW'(eye_z + longint'(int'($urandom_range(1 << 21)) - (1 << 20)));
    end
    return p;
  endfunction

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      cvt_pkg::REG_CAM_X:     eye_x = longint'($signed(data));
      cvt_pkg::REG_CAM_Y:     eye_y = longint'($signed(data));
      cvt_pkg::REG_CAM_Z:     eye_z = longint'($signed(data));
      cvt_pkg::REG_COS_PITCH: cos_p = longint'($signed(data[TW-1:0]));
      cvt_pkg::REG_SIN_PITCH: sin_p = longint'($signed(data[TW-1:0]));
      cvt_pkg::REG_COS_YAW:   cos_y = longint'($signed(data[TW-1:0]));
      cvt_pkg::REG_SIN_YAW:   sin_y = longint'($signed(data[TW-1:0]));
      default: ;
    endcase
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (views_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_point(vec_t p, logic known, vec_t res);
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= p.x;
    point_y <= p.y;
    point_z <= p.z;
    @(posedge clk iff in_ready);
    views_due.push_back(known ? res : camera_view(p));
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    vec_t want;
    if (!rst && out_valid && out_ready) begin
      if (views_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("view item with none due: %h %h %h", view_x, view_y, view_z);
      end else begin
        want = views_due.pop_front();
        if (want.x !== view_x || want.y !== view_y || want.z !== view_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("view mismatch: exp %h %h %h got %h %h %h",
                     want.x, want.y, want.z, view_x, view_y, view_z);
        end
      end
    end
  end

  initial begin
    vec_t p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        settle_outputs();
        write_reg(PLAN[r].idx, PLAN[r].data);
      end else begin
        send_point(PLAN[r].pt, PLAN[r].known, PLAN[r].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_outputs();
      steady = (ph >= 12 && ph < 16);
      // phase 1 and 2 put every register at its low and high extreme
      write_reg(cvt_pkg::REG_CAM_X, ph == 1 ? C_MIN : ph == 2 ? C_MAX : pick_coord());
      write_reg(cvt_pkg::REG_CAM_Y, ph == 1 ? C_MIN : ph == 2 ? C_MAX : pick_coord());
      write_reg(cvt_pkg::REG_CAM_Z, ph == 1 ? C_MIN : ph == 2 ? C_MAX : pick_coord());
      write_reg(cvt_pkg::REG_COS_PITCH,
                {16'($urandom()), ph == 1 ? 16'h8000 : ph == 2 ? 16'h7fff : pick_trig()});
      write_reg(cvt_pkg::REG_SIN_PITCH,
                {16'($urandom()), ph == 1 ? 16'h8000 : ph == 2 ? 16'h7fff : pick_trig()});
      write_reg(cvt_pkg::REG_COS_YAW,
                {16'($urandom()), ph == 1 ? 16'h8000 : ph == 2 ? 16'h7fff : pick_trig()});
      write_reg(cvt_pkg::REG_SIN_YAW,
                {16'($urandom()), ph == 1 ? 16'h8000 : ph == 2 ? 16'h7fff : pick_trig()});
      if ($urandom_range(3) == 0)
        write_reg(REG_UNUSED, $urandom());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2)
          settle_outputs();
        p = pick_point();
        send_point(p, 1'b0, p);
      end
    end

    settle_outputs();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_camera_view_transform OK");
    end else begin
      $display("tb_camera_view_transform NOT OK");
    end
    $finish;
  end

endmodule
